// ===== sv/sdm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdm_pkg: shared types and constants of the session deadline monitor
// Command and status codes, the table entry layout and the sequencer states.
// ----------------------------------------------------------------------------
package sdm_pkg;

  localparam int KEY_W  = 32;
  localparam int TIME_W = 63;

  // Deadline "never": the largest time value
  localparam logic [TIME_W-1:0] NEVER = {TIME_W{1'b1}};

  // Command codes
  localparam logic [2:0] CMD_REGISTER   = 3'd0;
  localparam logic [2:0] CMD_UNREGISTER = 3'd1;
  localparam logic [2:0] CMD_SET_DL     = 3'd2;
  localparam logic [2:0] CMD_CHECK      = 3'd3;
  localparam logic [2:0] CMD_NEXT       = 3'd4;

  // Status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOT_REG = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  // One session table entry
  typedef struct packed {
    logic              used;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] deadline;
  } sdm_entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN1,
    ST_UPDATE,
    ST_SCAN2,
    ST_FINISH
  } sdm_state_t;

endpackage : sdm_pkg
`default_nettype wire

// ===== sv/sdm_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdm_table: session table storage
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module sdm_table
  import sdm_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire sdm_entry_t    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output      sdm_entry_t    rd_data
);

  sdm_entry_t mem [DEPTH];
  sdm_entry_t rd_data_r;

  // Write one entry, read one entry per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule : sdm_table
`default_nettype wire

// ===== sv/session_deadline_monitor_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// session_deadline_monitor_unit: session table with earliest-deadline search
// Register, unregister, set-deadline, check and next commands over a table
// of SESSIONS entries, searched by one shared compare unit.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the table and holds
// in_tready low meanwhile. Each command then reads the table through its
// single read port, one entry per cycle. Check, next and commands that
// leave the table as it is take one pass; register, unregister and
// set-deadline that change an entry take a second pass to find the new
// earliest deadline. One command is in work at a time; the result waits in
// an output register, so the next command may be taken while the previous
// result is still pending. Ties on deadline go to the lowest slot.
module session_deadline_monitor_unit
  import sdm_pkg::*;
#(
  parameter int SESSIONS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Command requests
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [95:0]  in_tdata,   // [31:0] session_key, [94:32] time_ms
  input  wire logic [2:0]   in_tuser,   // [2:0] cmd
  // Results
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  output      logic [103:0] out_tdata   // [1:0] status, [2] expired_valid,
                                        // [34:3] expired_key,
                                        // [97:35] next_deadline, [98] any_session
);

  localparam int AW = $clog2(SESSIONS);
  localparam logic [AW:0] NUM_SLOTS = (AW+1)'(SESSIONS);

  // Sequencer and scan state
  sdm_state_t        state_r, state_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              rvld_r, rvld_nxt;
  logic [AW-1:0]     ridx_r, ridx_nxt;

  // Latched command
  logic [2:0]        cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;

  // Search results
  logic              match_vld_r, match_vld_nxt;
  logic [AW-1:0]     match_idx_r, match_idx_nxt;
  logic              free_vld_r, free_vld_nxt;
  logic [AW-1:0]     free_idx_r, free_idx_nxt;
  logic              best_vld_r, best_vld_nxt;
  logic [TIME_W-1:0] best_dl_r, best_dl_nxt;
  logic [KEY_W-1:0]  best_key_r, best_key_nxt;
  logic [1:0]        status_r, status_nxt;

  // Output register
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [1:0]        o_status_r, o_status_nxt;
  logic              o_exp_vld_r, o_exp_vld_nxt;
  logic [KEY_W-1:0]  o_exp_key_r, o_exp_key_nxt;
  logic [TIME_W-1:0] o_next_r, o_next_nxt;
  logic              o_any_r, o_any_nxt;

  // Table port
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  sdm_entry_t        wr_data;
  logic [AW-1:0]     rd_addr;
  sdm_entry_t        rd_data;

  // Shared compare unit outputs
  logic              key_hit;
  logic              earlier;
  logic              expired;

  sdm_table #(
    .DEPTH (SESSIONS),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Compare the returned entry against the command key and the best so far
  assign key_hit = rd_data.used && (rd_data.key == key_r);
  assign earlier = rd_data.used && (!best_vld_r || (rd_data.deadline < best_dl_r));
  assign expired = (cmd_r == CMD_CHECK) && best_vld_r && (best_dl_r <= time_r);

  // Next state and datapath
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rvld_nxt       = rvld_r;
    ridx_nxt       = ridx_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    time_nxt       = time_r;
    match_vld_nxt  = match_vld_r;
    match_idx_nxt  = match_idx_r;
    free_vld_nxt   = free_vld_r;
    free_idx_nxt   = free_idx_r;
    best_vld_nxt   = best_vld_r;
    best_dl_nxt    = best_dl_r;
    best_key_nxt   = best_key_r;
    status_nxt     = status_r;
    out_tvalid_nxt = out_tvalid_r;
    o_status_nxt   = o_status_r;
    o_exp_vld_nxt  = o_exp_vld_r;
    o_exp_key_nxt  = o_exp_key_r;
    o_next_nxt     = o_next_r;
    o_any_nxt      = o_any_r;
    rd_addr        = cnt_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = cnt_r[AW-1:0];
    wr_data        = '0;

    // Fold one returned entry into the search results
    if (rvld_r) begin
      if (key_hit && !match_vld_r) begin
        match_vld_nxt = 1'b1;
        match_idx_nxt = ridx_r;
      end
      if (!rd_data.used && !free_vld_r) begin
        free_vld_nxt = 1'b1;
        free_idx_nxt = ridx_r;
      end
      if (earlier) begin
        best_vld_nxt = 1'b1;
        best_dl_nxt  = rd_data.deadline;
        best_key_nxt = rd_data.key;
      end
    end

    // Drop the result once taken
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (cnt_r == NUM_SLOTS - 1'b1) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt       = in_tuser;
          key_nxt       = in_tdata[31:0];
          time_nxt      = in_tdata[94:32];
          match_vld_nxt = 1'b0;
          free_vld_nxt  = 1'b0;
          best_vld_nxt  = 1'b0;
          status_nxt    = STATUS_OK;
          cnt_nxt       = '0;
          state_nxt     = ST_SCAN1;
        end
      end
      ST_SCAN1, ST_SCAN2: begin
        if (cnt_r != NUM_SLOTS) begin
          rvld_nxt = 1'b1;
          ridx_nxt = cnt_r[AW-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          rvld_nxt = 1'b0;
          if (!rvld_r) begin
            state_nxt = (state_r == ST_SCAN1) ? ST_UPDATE : ST_FINISH;
          end
        end
      end
      ST_UPDATE: begin
        // Apply any table change, then rescan for the earliest deadline when an entry changed
        cnt_nxt      = '0;
        best_vld_nxt = 1'b0;
        state_nxt    = ST_FINISH;
        case (cmd_r)
          CMD_REGISTER: begin
            if (match_vld_r) begin
              best_vld_nxt = best_vld_r;
            end else if (free_vld_r) begin
              wr_en     = 1'b1;
              wr_addr   = free_idx_r;
              wr_data   = '{used: 1'b1, key: key_r, deadline: NEVER};
              state_nxt = ST_SCAN2;
            end else begin
              best_vld_nxt = best_vld_r;
              status_nxt   = STATUS_FULL;
            end
          end
          CMD_UNREGISTER: begin
            if (match_vld_r) begin
              wr_en     = 1'b1;
              wr_addr   = match_idx_r;
              wr_data   = '{used: 1'b0, key: key_r, deadline: NEVER};
              state_nxt = ST_SCAN2;
            end else begin
              best_vld_nxt = best_vld_r;
              status_nxt   = STATUS_NOT_REG;
            end
          end
          CMD_SET_DL: begin
            if (match_vld_r) begin
              wr_en     = 1'b1;
              wr_addr   = match_idx_r;
              wr_data   = '{used: 1'b1, key: key_r, deadline: time_r};
              state_nxt = ST_SCAN2;
            end else begin
              best_vld_nxt = best_vld_r;
              status_nxt   = STATUS_NOT_REG;
            end
          end
          default: begin
            best_vld_nxt = best_vld_r;
          end
        endcase
      end
      ST_FINISH: begin
        // Load the result once the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          o_status_nxt   = status_r;
          o_exp_vld_nxt  = expired;
          o_exp_key_nxt  = expired ? best_key_r : '0;
          o_next_nxt     = best_vld_r ? best_dl_r : NEVER;
          o_any_nxt      = best_vld_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      rvld_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      rvld_r       <= rvld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ridx_r      <= ridx_nxt;
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    time_r      <= time_nxt;
    match_vld_r <= match_vld_nxt;
    match_idx_r <= match_idx_nxt;
    free_vld_r  <= free_vld_nxt;
    free_idx_r  <= free_idx_nxt;
    best_vld_r  <= best_vld_nxt;
    best_dl_r   <= best_dl_nxt;
    best_key_r  <= best_key_nxt;
    status_r    <= status_nxt;
    o_status_r  <= o_status_nxt;
    o_exp_vld_r <= o_exp_vld_nxt;
    o_exp_key_r <= o_exp_key_nxt;
    o_next_r    <= o_next_nxt;
    o_any_r     <= o_any_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, o_any_r, o_next_r, o_exp_key_r, o_exp_vld_r, o_status_r};

  // A taken request closes the input until its command is done
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready while a command is in work");

  // An expired session is only reported with status ok and a nonempty table
  a_expired_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] == STATUS_OK && out_tdata[98])
    else $error("expired session reported with bad status or empty table");

  // An empty table reports a deadline of never
  a_empty_never: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[98] |-> out_tdata[97:35] == NEVER)
    else $error("empty table with a finite next deadline");

endmodule : session_deadline_monitor_unit
`default_nettype wire

// ===== sim/sdm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sdm_checker: result predictor and comparator for the deadline monitor
// Watches the command and result streams. For each accepted command request
// it updates its own session table and queues the expected result. Each
// accepted result is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module sdm_checker
  import sdm_pkg::*;
#(
  parameter int SESSIONS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [95:0]  in_tdata,   // [31:0] session_key, [94:32] time_ms
  input  wire logic [2:0]   in_tuser,   // [2:0] cmd
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [103:0] out_tdata,  // [1:0] status, [2] expired_valid,
                                        // [34:3] expired_key,
                                        // [97:35] next_deadline, [98] any_session
  output int                fail_count,
  output int                pending
);

  localparam int REPORT_LIMIT = 10;

  // Result layout, lowest field last so it lines up with out_tdata[98:0]
  typedef struct packed {
    logic              any_session;
    logic [TIME_W-1:0] next_deadline;
    logic [KEY_W-1:0]  expired_key;
    logic              expired_valid;
    logic [1:0]        status;
  } deadline_result_t;

  // Shadow session table
  logic              session_used     [SESSIONS];
  logic [KEY_W-1:0]  session_key      [SESSIONS];
  logic [TIME_W-1:0] session_deadline [SESSIONS];

  deadline_result_t expected_results [$];

  // Lowest slot holding the earliest deadline, -1 when the table is empty
  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < SESSIONS; i++) begin
      if (session_used[i] && (best < 0 || session_deadline[i] < session_deadline[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  // Apply one command to the shadow table and return the result it produces
  function automatic deadline_result_t predict_command_result(
    input logic [2:0]        cmd,
    input logic [KEY_W-1:0]  key,
    input logic [TIME_W-1:0] now_ms
  );
    deadline_result_t res;
    int               hit;
    int               free_idx;
    int               top;
    res      = '0;
    res.status = STATUS_OK;
    hit      = -1;
    free_idx = -1;
    for (int i = 0; i < SESSIONS; i++) begin
      if (session_used[i] && session_key[i] == key && hit < 0) begin
        hit = i;
      end
      if (!session_used[i] && free_idx < 0) begin
        free_idx = i;
      end
    end
    case (cmd)
      CMD_REGISTER: begin
        // a present key is left alone
        if (hit < 0) begin
          if (free_idx < 0) begin
            res.status = STATUS_FULL;
          end else begin
            session_used[free_idx]     = 1'b1;
            session_key[free_idx]      = key;
            session_deadline[free_idx] = NEVER;
          end
        end
      end
      CMD_UNREGISTER: begin
        if (hit < 0) begin
          res.status = STATUS_NOT_REG;
        end else begin
          session_used[hit] = 1'b0;
        end
      end
      CMD_SET_DL: begin
        if (hit < 0) begin
          res.status = STATUS_NOT_REG;
        end else begin
          session_deadline[hit] = now_ms;
        end
      end
      CMD_CHECK: begin
        top = earliest_slot();
        if (top >= 0 && session_deadline[top] <= now_ms) begin
          res.expired_valid = 1'b1;
          res.expired_key   = session_key[top];
        end
      end
      default: begin
        // next timeout and unused codes only report
      end
    endcase
    top = earliest_slot();
    res.any_session   = (top >= 0);
    res.next_deadline = (top >= 0) ? session_deadline[top] : NEVER;
    return res;
  endfunction

  // Compare results first, then predict the newly accepted request
  always @(posedge clk) begin
    deadline_result_t got;
    deadline_result_t want;
    logic             bad;
    if (!rst_n) begin
      for (int i = 0; i < SESSIONS; i++) begin
        session_used[i] = 1'b0;
      end
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[98:0];
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected result %h with nothing pending", $realtime, got);
          end
        end else begin
          want = expected_results.pop_front();
          bad  = (got.status !== want.status) ||
                 (got.expired_valid !== want.expired_valid) ||
                 (got.expired_key !== want.expired_key) ||
                 (got.next_deadline !== want.next_deadline) ||
                 (got.any_session !== want.any_session);
          if (bad) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("%0t: result mismatch (expected / actual)", $realtime);
              $display("  status %0d / %0d, expired_valid %0d / %0d, expired_key %h / %h",
                       want.status, got.status, want.expired_valid, got.expired_valid,
                       want.expired_key, got.expired_key);
              $display("  next_deadline %h / %h, any_session %0d / %0d",
                       want.next_deadline, got.next_deadline,
                       want.any_session, got.any_session);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(
          predict_command_result(in_tuser, in_tdata[KEY_W-1:0], in_tdata[KEY_W+TIME_W-1:KEY_W]));
      end
    end
    pending = expected_results.size();
  end

endmodule : sdm_checker

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the session deadline monitor
// Drives directed command requests, then random register / unregister /
// set-deadline / check / next traffic over a small key pool in four idling
// phases, with one long result hold-off. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top
  import sdm_pkg::*;
;

  localparam int SESSIONS       = 64;
  localparam int POOL_SIZE      = 72;
  localparam int PHASE_ITEMS    = 300;
  localparam int BIAS_RUN       = 75;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;   // [31:0] session_key, [94:32] time_ms
  logic [2:0]   in_tuser;   // [2:0] cmd
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;  // [1:0] status, [2] expired_valid, [34:3] expired_key,
                            // [97:35] next_deadline, [98] any_session

  int fail_count;
  int pending;
  int snd_idle    = 0;
  int rcv_stall   = 0;
  int idle_cycles = 0;
  logic hold_req  = 1'b0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  session_deadline_monitor_unit #(
    .SESSIONS (SESSIONS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sdm_checker #(
    .SESSIONS (SESSIONS)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rcv_stall);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one command request and hold it until accepted
  task automatic send_command(
    input logic [2:0]        cmd,
    input logic [KEY_W-1:0]  key,
    input logic [TIME_W-1:0] at_ms
  );
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, at_ms, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly small times so deadlines and checks collide, some extremes
  function automatic logic [TIME_W-1:0] random_time();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return TIME_W'($urandom_range(0, 1023));
    if (pick < 70) return NEVER;
    if (pick < 75) return '0;
    return TIME_W'({$urandom, $urandom});
  endfunction

  // Pool keys keep lookups hitting; filling runs push the table to full
  task automatic random_command(input bit filling);
    int               pick;
    logic [2:0]       cmd;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(0, 99);
    key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if ($urandom_range(0, 19) == 0) key = $urandom;
    if (pick < 5) begin
      cmd = CMD_NEXT + 3'($urandom_range(1, 3));
    end else if (pick < 10) begin
      cmd = CMD_NEXT;
    end else if (pick < 25) begin
      cmd = CMD_CHECK;
    end else if (pick < 45) begin
      cmd = CMD_SET_DL;
    end else if (pick < (filling ? 95 : 55)) begin
      cmd = CMD_REGISTER;
    end else begin
      cmd = CMD_UNREGISTER;
    end
    send_command(cmd, key, random_time());
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_REGISTER;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table, unknown keys
    send_command(CMD_CHECK, '0, '0);
    send_command(CMD_NEXT, '1, NEVER);
    send_command(CMD_UNREGISTER, 32'h1234_5678, '0);
    send_command(CMD_SET_DL, '1, TIME_W'(5));
    // Extreme keys, duplicate register
    send_command(CMD_REGISTER, '0, '0);
    send_command(CMD_REGISTER, '1, NEVER);
    send_command(CMD_REGISTER, '0, TIME_W'(7));
    // Never deadlines: expire only at time never, lowest slot on the tie
    send_command(CMD_CHECK, '0, '0);
    send_command(CMD_CHECK, '0, NEVER - 1'b1);
    send_command(CMD_CHECK, '0, NEVER);
    // Earliest deadline and tie between slots
    send_command(CMD_SET_DL, '1, '0);
    send_command(CMD_CHECK, '0, '0);
    send_command(CMD_SET_DL, '0, '0);
    send_command(CMD_CHECK, '1, '0);
    send_command(CMD_SET_DL, '0, NEVER ^ TIME_W'({32{2'b01}}));
    send_command(CMD_SET_DL, '1, NEVER);
    send_command(CMD_NEXT, '0, '0);
    // Unused command codes
    for (int n = 1; n <= 3; n++) begin
      send_command(CMD_NEXT + 3'(n), $urandom, random_time());
    end
    // Drain back to empty
    send_command(CMD_UNREGISTER, '1, '0);
    send_command(CMD_UNREGISTER, '0, '0);
    send_command(CMD_CHECK, '0, NEVER);
    send_command(CMD_NEXT, '0, '0);

    // Random traffic in four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          snd_idle = 0;
          rcv_stall <= 0;
          hold_req  <= 1'b1;
        end
        1: begin
          snd_idle = 87;
          rcv_stall <= 0;
        end
        2: begin
          snd_idle = 0;
          rcv_stall <= 87;
        end
        default: begin
          snd_idle = 35;
          rcv_stall <= 35;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_command(((n / BIAS_RUN) % 2) == 0);
      end
    end
    in_tvalid <= 1'b0;

    // Wait for the last results, then let the block settle
    while (pending != 0) @(negedge clk);
    repeat (2 * SESSIONS + 8) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule : tb_top
